// ===== design/chd_pkg.sv =====
// Shared types and constants for the convex hull diameter block.
package chd_pkg;

  localparam int IdBits   = 10;
  localparam int DiamBits = 33;

  // One stored hull vertex.
  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic [IdBits-1:0]  id;
  } hull_pt_t;

endpackage

// ===== design/convex_hull_diameter.sv =====
// Convex hull diameter: monotone-chain hull build and rotating-caliper search.
// Load: per hull, each point pops entries that fail the turn test (LREQ, LWAIT, LCHK,
// LDEC) and is then pushed (LPUSH); a hull of fewer than two entries skips the test.
// After the last point the caliper walk steps through CREQ, CWAIT, CMUL and CDEC, about
// one step per hull vertex; the pairs then leave through a registered output stage.
// rst (synchronous, active high) empties both hulls and the pair list; no clearing pass.
module convex_hull_diameter #(
  parameter int MAX_POINTS = 1024,
  parameter int MAX_PAIRS  = 64,
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // x[15:0], y[31:16], point_id[41:32], zero pad
  input  logic        s_tlast,   // last_point
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // diameter_sq[32:0], id_a[42:33], id_b[52:43], zero pad
  output logic        m_tlast,   // last_pair
  output logic        m_tuser    // truncated
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int PW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int NW = $clog2(MAX_PAIRS + 1);
  localparam int DW = 2 * COORD_BITS + 2;

  localparam logic [3:0] S_IDLE = 4'd0, S_LREQ = 4'd1, S_LCHK = 4'd2, S_LPUSH = 4'd3,
                         S_CREQ = 4'd4, S_CMUL = 4'd5, S_CDEC = 4'd6, S_EMIT = 4'd7,
                         S_EWAIT = 4'd8, S_SINGLE = 4'd9, S_LWAIT = 4'd10,
                         S_LDEC = 4'd11, S_CWAIT = 4'd12;

  chd_pkg::hull_pt_t ustk [MAX_POINTS];
  chd_pkg::hull_pt_t lstk [MAX_POINTS];
  logic [2*chd_pkg::IdBits-1:0] plist [MAX_PAIRS];

  logic [3:0] state;
  logic       side;      // 0: upper hull, 1: lower hull
  logic       fin;
  chd_pkg::hull_pt_t p;
  logic [CW-1:0] ucnt, lcnt, c;
  logic [AW-1:0] ra0, ra1, rb0, rb1;
  chd_pkg::hull_pt_t ua, ub, la, lb;  // registered read data
  logic [CW-1:0] ci, cj;
  logic [DW-1:0] best;
  logic          best_valid;
  logic [NW-1:0] pcnt, ecnt;
  logic          dropped;
  logic signed [2*COORD_BITS+3:0] m1, m2;
  logic [2*chd_pkg::IdBits-1:0] prd;

  // Read ports: two per hull memory, registered.
  always_ff @(posedge clk) begin
    ua <= ustk[ra0];
    ub <= ustk[ra1];
    la <= lstk[rb0];
    lb <= lstk[rb1];
    prd <= plist[ecnt[PW-1:0]];
  end

  logic signed [COORD_BITS:0] ex1, ey1, ex2, ey2;
  chd_pkg::hull_pt_t ta, tb;
  always_comb begin
    ta = side ? la : ua;
    tb = side ? lb : ub;
    ex1 = (COORD_BITS+1)'($signed(tb.x[COORD_BITS-1:0])) - (COORD_BITS+1)'($signed(ta.x[COORD_BITS-1:0]));
    ey1 = (COORD_BITS+1)'($signed(tb.y[COORD_BITS-1:0])) - (COORD_BITS+1)'($signed(ta.y[COORD_BITS-1:0]));
    ex2 = (COORD_BITS+1)'($signed(p.x[COORD_BITS-1:0])) - (COORD_BITS+1)'($signed(ta.x[COORD_BITS-1:0]));
    ey2 = (COORD_BITS+1)'($signed(p.y[COORD_BITS-1:0])) - (COORD_BITS+1)'($signed(ta.y[COORD_BITS-1:0]));
  end

  // Caliper differences: upper edge i..i+1 and lower edge j-1..j; pair distance.
  logic signed [COORD_BITS:0] dux, duy, dlx, dly, ddx, ddy;
  always_comb begin
    dux = (COORD_BITS+1)'($signed(ub.x[COORD_BITS-1:0])) - (COORD_BITS+1)'($signed(ua.x[COORD_BITS-1:0]));
    duy = (COORD_BITS+1)'($signed(ub.y[COORD_BITS-1:0])) - (COORD_BITS+1)'($signed(ua.y[COORD_BITS-1:0]));
    dlx = (COORD_BITS+1)'($signed(lb.x[COORD_BITS-1:0])) - (COORD_BITS+1)'($signed(la.x[COORD_BITS-1:0]));
    dly = (COORD_BITS+1)'($signed(lb.y[COORD_BITS-1:0])) - (COORD_BITS+1)'($signed(la.y[COORD_BITS-1:0]));
    ddx = (COORD_BITS+1)'($signed(ua.x[COORD_BITS-1:0])) - (COORD_BITS+1)'($signed(lb.x[COORD_BITS-1:0]));
    ddy = (COORD_BITS+1)'($signed(ua.y[COORD_BITS-1:0])) - (COORD_BITS+1)'($signed(lb.y[COORD_BITS-1:0]));
  end

  logic signed [2*COORD_BITS+3:0] cr;
  logic pop;
  always_comb begin
    cr = m1 - m2;
    pop = side ? (cr <= 0) : (cr >= 0);
  end

  logic [DW-1:0] sqx, sqy;
  logic [DW-1:0] dx_sq_next;
  logic ulast, jzero;
  assign ulast = (ci == ucnt - CW'(1));
  assign jzero = (cj == '0);
  assign dx_sq_next = sqx + sqy;

  logic [COORD_BITS-1:0] adx, ady;
  assign adx = ddx[COORD_BITS] ? COORD_BITS'(-ddx) : COORD_BITS'(ddx);
  assign ady = ddy[COORD_BITS] ? COORD_BITS'(-ddy) : COORD_BITS'(ddy);

  assign s_tready = (state == S_IDLE) && !m_tvalid;

  // The distance width can exceed or fall short of the output field.
  function automatic logic [chd_pkg::DiamBits-1:0] DiamTrunc(input logic [DW-1:0] v);
    logic [DW+chd_pkg::DiamBits-1:0] w;
    w = {{chd_pkg::DiamBits{1'b0}}, v};
    return w[chd_pkg::DiamBits-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ucnt <= '0; lcnt <= '0;
      best_valid <= 1'b0; pcnt <= '0; dropped <= 1'b0;
      m_tvalid <= 1'b0;
      side <= 1'b0; fin <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_EWAIT) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            p.x <= 24'(s_tdata[15:0]);
            p.y <= 24'(s_tdata[31:16]);
            p.id <= s_tdata[41:32];
            fin <= s_tlast;
            side <= 1'b0;
            c <= ucnt;
            state <= S_LREQ;
          end
        end
        S_LREQ: begin
          if (c > CW'(1)) begin
            ra0 <= AW'(c - CW'(2)); ra1 <= AW'(c - CW'(1));
            rb0 <= AW'(c - CW'(2)); rb1 <= AW'(c - CW'(1));
            state <= S_LWAIT;
          end else state <= S_LPUSH;
        end
        S_LWAIT: begin
          state <= S_LCHK;
        end
        S_LCHK: begin
          m1 <= ex1 * ey2;
          m2 <= ey1 * ex2;
          state <= S_LDEC;
        end
        S_LDEC: begin
          // Hull load turn test.
          if (pop) begin c <= c - CW'(1); state <= S_LREQ; end
          else state <= S_LPUSH;
        end
        S_LPUSH: begin
          if (c >= CW'(MAX_POINTS)) begin
            if (side) lstk[AW'(MAX_POINTS - 1)] <= p; else ustk[AW'(MAX_POINTS - 1)] <= p;
            if (side) lcnt <= CW'(MAX_POINTS); else ucnt <= CW'(MAX_POINTS);
          end else begin
            if (side) lstk[AW'(c)] <= p; else ustk[AW'(c)] <= p;
            if (side) lcnt <= c + CW'(1); else ucnt <= c + CW'(1);
          end
          if (!side) begin
            side <= 1'b1; c <= lcnt; state <= S_LREQ;
          end else if (fin) begin
            ci <= '0;
            cj <= ((c >= CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : c + CW'(1)) - CW'(1);
            state <= S_SINGLE;
          end else state <= S_IDLE;
        end
        S_SINGLE: begin
          // Only one point on both hulls: it pairs with itself.
          if (ucnt == CW'(1) && cj == '0) begin
            ra0 <= '0; rb1 <= '0; state <= S_CWAIT;
          end else state <= S_CREQ;
        end
        S_CREQ: begin
          if (!ulast || !jzero) begin
            ra0 <= AW'(ci); ra1 <= AW'(ci + CW'(1));
            rb0 <= AW'(cj - CW'(1)); rb1 <= AW'(cj);
            state <= S_CWAIT;
          end else begin
            ecnt <= '0; state <= S_EMIT;
          end
        end
        S_CWAIT: begin
          state <= S_CMUL;
        end
        S_CMUL: begin
          sqx <= DW'(adx * adx);
          sqy <= DW'(ady * ady);
          m1 <= duy * dlx;
          m2 <= dly * dux;
          side <= 1'b0;
          state <= S_CDEC;
          fin <= 1'b0;
        end
        S_CDEC: begin
          if (!best_valid || dx_sq_next > best) begin
            best <= dx_sq_next; best_valid <= 1'b1; dropped <= 1'b0;
            plist[0] <= {lb.id, ua.id}; pcnt <= NW'(1);
          end else if (dx_sq_next == best) begin
            if (pcnt < NW'(MAX_PAIRS)) begin
              plist[PW'(pcnt)] <= {lb.id, ua.id}; pcnt <= pcnt + NW'(1);
            end else dropped <= 1'b1;
          end
          if (ucnt == CW'(1) && cj == '0 && ci == '0 && !best_valid) begin
            ecnt <= '0; state <= S_EMIT;
          end else begin
            if (ulast) cj <= cj - CW'(1);
            else if (jzero) ci <= ci + CW'(1);
            else if (m1 > m2) ci <= ci + CW'(1);
            else cj <= cj - CW'(1);
            state <= S_CREQ;
          end
        end
        S_EMIT: begin
          state <= S_EWAIT;
        end
        S_EWAIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata <= {3'b0, prd[19:10], prd[9:0], DiamTrunc(best)};
            m_tlast <= (ecnt + NW'(1) == pcnt);
            m_tuser <= dropped;
            ecnt <= ecnt + NW'(1);
            if (ecnt + NW'(1) == pcnt) begin
              ucnt <= '0; lcnt <= '0; best_valid <= 1'b0; pcnt <= '0;
              dropped <= 1'b0; state <= S_IDLE;
            end else state <= S_EMIT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  ap_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> state == S_IDLE) else $error("ready outside idle");
  ap_pcnt_cap: assert property (@(posedge clk) disable iff (rst)
    pcnt <= NW'(MAX_PAIRS)) else $error("pair count overflow");
  ap_last_empty: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> pcnt == '0) else $error("pairs kept after run");
  ap_cnt_cap: assert property (@(posedge clk) disable iff (rst)
    ucnt <= CW'(MAX_POINTS) && lcnt <= CW'(MAX_POINTS)) else $error("hull count overflow");

endmodule
